[hdl/psin_pkg.sv]
// Shared types and constants for the parametric sine oscillator.
// No dependencies; imported by every module of the block.
package psin_pkg;

   localparam int DATA_W       = 32;
   localparam int IDX_W        = 3;
   localparam int PROD_W       = 64;
   localparam int REM_W        = 19;
   localparam int ANG_W        = 34;
   localparam int CORDIC_STEPS = 30;
   localparam int QUEUE_DEPTH  = 2;
   localparam int OUT_DEPTH    = 2;

   localparam logic [REM_W-1:0]        TWO_PI_Q16    = 19'd411775;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30   = 34'sd1686630400;
   localparam logic signed [ANG_W-1:0] PI_Q30        = 34'sd3373260800;
   localparam logic signed [ANG_W-1:0] TWO_PI_Q30    = 34'sd6746521600;
   localparam logic signed [ANG_W-1:0] CORDIC_GAIN   = 34'sd652032874;
   localparam logic [DATA_W-1:0]       PHASE_X_RESET = 32'd102943;
   localparam logic [DATA_W-1:0]       ONE_Q16       = 32'd65536;

   // floor(2^38 / 2pi_q16) and 2^32 mod 2pi_q16, for the angle reduction
   localparam logic [19:0]             RECIP_Q38     = 20'd667543;
   localparam logic [17:0]             TWO32_MOD     = 18'd154046;

   localparam logic signed [ANG_W-1:0] ATAN_Q30 [CORDIC_STEPS] = '{
      34'sd843314857, 34'sd497837829, 34'sd263043836, 34'sd133525158, 34'sd67021686,
      34'sd33543515, 34'sd16775850, 34'sd8388437, 34'sd4194282, 34'sd2097149,
      34'sd1048575, 34'sd524287, 34'sd262143, 34'sd131071, 34'sd65535,
      34'sd32767, 34'sd16383, 34'sd8191, 34'sd4095, 34'sd2047,
      34'sd1023, 34'sd511, 34'sd255, 34'sd127, 34'sd63,
      34'sd31, 34'sd15, 34'sd8, 34'sd4, 34'sd2
   };

   typedef enum logic [IDX_W-1:0] {
      REG_SPEED  = 3'd0,
      REG_AMP    = 3'd1,
      REG_SCALE  = 3'd2,
      REG_PERIOD = 3'd3,
      REG_PHASE  = 3'd4,
      REG_OFFSET = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] speed;
      logic signed [DATA_W-1:0] amp;
      logic signed [DATA_W-1:0] scale;
      logic signed [DATA_W-1:0] period;
      logic signed [DATA_W-1:0] phase;
      logic signed [DATA_W-1:0] offset;
   } psin_cfg_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] time_bars;
      logic                     period_zero;
   } psin_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     period_zero;
      logic                     saturated;
   } psin_result_type;

   typedef struct packed {
      logic valid;
      logic advance;
   } psin_flow_type;

endpackage

[hdl/psin_front.sv]
// Front end: takes input transactions, tags zero-period items, holds them in a short queue.
// Depends on psin_pkg.
module psin_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic signed [31:0]           req_time_bars,
   input  psin_pkg::psin_cfg_type       cfg,
   input  logic                         advance,
   output psin_pkg::psin_flow_type      flow,
   output psin_pkg::psin_item_type      head
);
   import psin_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   psin_item_type    queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;
   psin_item_type    new_item;

   assign req_full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push     = req_push && !req_full;
   assign pop      = advance && (count_ff != '0);

   assign new_item.time_bars   = req_time_bars;
   assign new_item.period_zero = (cfg.period == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign flow.valid   = (count_ff != '0);
   assign flow.advance = advance;
   assign head         = queue_ff[rd_ptr_ff];

endmodule

[hdl/psin_div.sv]
// Pipelined restoring divider, one quotient bit per stage, unsigned core with sign fix-up.
// Depends on psin_pkg.
module psin_div (
   input  logic                        clock,
   input  logic                        reset,
   input  psin_pkg::psin_flow_type     flow,
   input  logic [63:0]                 num,
   input  logic [31:0]                 den,
   input  logic                        neg,
   input  logic                        tag_in,
   output logic                        q_valid,
   output logic signed [63:0]          quotient,
   output logic                        tag_out
);
   import psin_pkg::*;

   localparam int N = PROD_W;

   logic [DATA_W-1:0] rem_ff [N];
   logic [N-1:0]      nq_ff  [N];
   logic              neg_ff [N];
   logic              tag_ff [N];
   logic              v_ff   [N];

   logic [DATA_W-1:0] rem_w [N+1];
   logic [N-1:0]      nq_w  [N+1];
   logic              neg_w [N+1];
   logic              tag_w [N+1];
   logic              v_w   [N+1];

   assign rem_w[0] = '0;
   assign nq_w[0]  = num;
   assign neg_w[0] = neg;
   assign tag_w[0] = tag_in;
   assign v_w[0]   = flow.valid;

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [DATA_W:0] r2;
      logic [DATA_W:0] diff;
      logic            ge;

      assign r2   = {rem_w[k], nq_w[k][N-1]};
      assign diff = r2 - {1'b0, den};
      assign ge   = (r2 >= {1'b0, den});

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (flow.advance) begin
            v_ff[k] <= v_w[k];
         end
      end

      always_ff @(posedge clock) begin
         if (flow.advance) begin
            rem_ff[k] <= ge ? diff[DATA_W-1:0] : r2[DATA_W-1:0];
            nq_ff[k]  <= {nq_w[k][N-2:0], ge};
            neg_ff[k] <= neg_w[k];
            tag_ff[k] <= tag_w[k];
         end
      end

      assign rem_w[k+1] = rem_ff[k];
      assign nq_w[k+1]  = nq_ff[k];
      assign neg_w[k+1] = neg_ff[k];
      assign tag_w[k+1] = tag_ff[k];
      assign v_w[k+1]   = v_ff[k];
   end

   assign q_valid  = v_w[N];
   assign quotient = neg_w[N] ? -$signed(nq_w[N]) : $signed(nq_w[N]);
   assign tag_out  = tag_w[N];

endmodule

[hdl/psin_back.sv]
// Back end: time scaling, division, angle reduction, CORDIC sine, gain, offset and clipping.
// Depends on psin_pkg and psin_div.
module psin_back (
   input  logic                        clock,
   input  logic                        reset,
   input  psin_pkg::psin_flow_type     flow,
   input  psin_pkg::psin_item_type     item,
   input  psin_pkg::psin_cfg_type      cfg,
   output logic                        res_valid,
   output psin_pkg::psin_result_type   result
);
   import psin_pkg::*;

   localparam int RED_STAGES = 8;
   localparam logic signed [52:0] SUM_MAX = 53'sd2147483647;
   localparam logic signed [52:0] SUM_MIN = -53'sd2147483648;

   logic adv;
   assign adv = flow.advance;

   // time * speed
   logic                     mul_v_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     mul_pz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_v_ff <= 1'b0;
      end else if (adv) begin
         mul_v_ff <= flow.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff   <= PROD_W'(item.time_bars) * PROD_W'(cfg.speed);
         mul_pz_ff <= item.period_zero;
      end
   end

   logic [PROD_W-1:0] div_num;
   logic [DATA_W-1:0] div_den;
   logic              div_neg;
   logic              div_v;
   logic signed [PROD_W-1:0] quot;
   logic              div_pz;
   psin_flow_type     div_flow;

   assign div_num       = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
   assign div_den       = cfg.period[DATA_W-1] ? DATA_W'(-cfg.period) : DATA_W'(cfg.period);
   assign div_neg       = prod_ff[PROD_W-1] ^ cfg.period[DATA_W-1];
   assign div_flow.valid   = mul_v_ff;
   assign div_flow.advance = adv;

   psin_div u_div (
      .clock    (clock),
      .reset    (reset),
      .flow     (div_flow),
      .num      (div_num),
      .den      (div_den),
      .neg      (div_neg),
      .tag_in   (mul_pz_ff),
      .q_valid  (div_v),
      .quotient (quot),
      .tag_out  (div_pz)
   );

   // angle = quotient + phase
   logic                     ang_v_ff;
   logic signed [PROD_W-1:0] angle_ff;
   logic                     ang_pz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_v_ff <= 1'b0;
      end else if (adv) begin
         ang_v_ff <= div_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         angle_ff  <= quot + PROD_W'(cfg.phase);
         ang_pz_ff <= div_pz;
      end
   end

   // angle mod 2*pi on the magnitude: both 32-bit halves reduced by reciprocal
   // multiplication (estimate low by at most one), recombined via 2^32 mod 2*pi,
   // reduced once more, then floor correction for negative angles
   logic [RED_STAGES-1:0] red_v_ff, red_pz_ff;
   logic [RED_STAGES-2:0] red_neg_ff;
   logic [PROD_W-1:0]     ang_mag;
   logic [DATA_W-1:0]     rd0_hi_ff, rd0_lo_ff;
   logic [51:0]           rd1_ph, rd1_pl;
   logic [13:0]           rd1_qh_ff, rd1_ql_ff;
   logic [DATA_W-1:0]     rd1_hi_ff, rd1_lo_ff;
   logic [32:0]           rd2_dh, rd2_dl;
   logic [REM_W:0]        rd2_hr_ff, rd2_lr_ff;
   logic [REM_W-1:0]      rd3_hr_ff, rd3_lr_ff;
   logic [37:0]           rd4_v_ff;
   logic [57:0]           rd5_p;
   logic [19:0]           rd5_q_ff;
   logic [37:0]           rd5_v_ff;
   logic [38:0]           rd6_d;
   logic [REM_W:0]        rd6_r_ff;
   logic [REM_W-1:0]      rd6_rc;
   logic [REM_W-1:0]      rr_ff;

   assign ang_mag = angle_ff[PROD_W-1] ? PROD_W'(-angle_ff) : PROD_W'(angle_ff);
   assign rd1_ph  = 52'(rd0_hi_ff) * 52'(RECIP_Q38);
   assign rd1_pl  = 52'(rd0_lo_ff) * 52'(RECIP_Q38);
   assign rd2_dh  = 33'(rd1_hi_ff) - 33'(rd1_qh_ff) * 33'(TWO_PI_Q16);
   assign rd2_dl  = 33'(rd1_lo_ff) - 33'(rd1_ql_ff) * 33'(TWO_PI_Q16);
   assign rd5_p   = 58'(rd4_v_ff) * 58'(RECIP_Q38);
   assign rd6_d   = 39'(rd5_v_ff) - 39'(rd5_q_ff) * 39'(TWO_PI_Q16);
   assign rd6_rc  = (rd6_r_ff >= {1'b0, TWO_PI_Q16}) ?
                    REM_W'(rd6_r_ff - {1'b0, TWO_PI_Q16}) : rd6_r_ff[REM_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         red_v_ff <= '0;
      end else if (adv) begin
         red_v_ff <= {red_v_ff[RED_STAGES-2:0], ang_v_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         red_pz_ff  <= {red_pz_ff[RED_STAGES-2:0], ang_pz_ff};
         red_neg_ff <= {red_neg_ff[RED_STAGES-3:0], angle_ff[PROD_W-1]};
         rd0_hi_ff  <= ang_mag[PROD_W-1:DATA_W];
         rd0_lo_ff  <= ang_mag[DATA_W-1:0];
         rd1_qh_ff  <= rd1_ph[51:38];
         rd1_ql_ff  <= rd1_pl[51:38];
         rd1_hi_ff  <= rd0_hi_ff;
         rd1_lo_ff  <= rd0_lo_ff;
         rd2_hr_ff  <= rd2_dh[REM_W:0];
         rd2_lr_ff  <= rd2_dl[REM_W:0];
         rd3_hr_ff  <= (rd2_hr_ff >= {1'b0, TWO_PI_Q16}) ?
                       REM_W'(rd2_hr_ff - {1'b0, TWO_PI_Q16}) : rd2_hr_ff[REM_W-1:0];
         rd3_lr_ff  <= (rd2_lr_ff >= {1'b0, TWO_PI_Q16}) ?
                       REM_W'(rd2_lr_ff - {1'b0, TWO_PI_Q16}) : rd2_lr_ff[REM_W-1:0];
         rd4_v_ff   <= 38'(rd3_hr_ff) * 38'(TWO32_MOD) + 38'(rd3_lr_ff);
         rd5_q_ff   <= rd5_p[57:38];
         rd5_v_ff   <= rd4_v_ff;
         rd6_r_ff   <= rd6_d[REM_W:0];
         rr_ff      <= (red_neg_ff[RED_STAGES-2] && (rd6_rc != '0)) ?
                       TWO_PI_Q16 - rd6_rc : rd6_rc;
      end
   end

   // fold into [-pi/2, pi/2]
   logic signed [ANG_W-1:0] zq;
   logic signed [ANG_W-1:0] fold_in;
   logic signed [ANG_W-1:0] fold_ff;
   logic                    fold_v_ff;
   logic                    fold_pz_ff;

   assign zq = $signed({1'b0, rr_ff, 14'b0});

   always_comb begin
      if (zq <= HALF_PI_Q30) begin
         fold_in = zq;
      end else if (zq < PI_Q30 + HALF_PI_Q30) begin
         fold_in = PI_Q30 - zq;
      end else begin
         fold_in = zq - TWO_PI_Q30;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_v_ff <= 1'b0;
      end else if (adv) begin
         fold_v_ff <= red_v_ff[RED_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fold_ff    <= fold_in;
         fold_pz_ff <= red_pz_ff[RED_STAGES-1];
      end
   end

   // rotation-mode CORDIC, one micro-rotation per stage
   logic signed [ANG_W-1:0] cx_ff [CORDIC_STEPS];
   logic signed [ANG_W-1:0] cy_ff [CORDIC_STEPS];
   logic signed [ANG_W-1:0] cz_ff [CORDIC_STEPS];
   logic                    cpz_ff [CORDIC_STEPS];
   logic                    cv_ff  [CORDIC_STEPS];

   logic signed [ANG_W-1:0] cx_w [CORDIC_STEPS+1];
   logic signed [ANG_W-1:0] cy_w [CORDIC_STEPS+1];
   logic signed [ANG_W-1:0] cz_w [CORDIC_STEPS+1];
   logic                    cpz_w [CORDIC_STEPS+1];
   logic                    cv_w  [CORDIC_STEPS+1];

   assign cx_w[0]  = CORDIC_GAIN;
   assign cy_w[0]  = '0;
   assign cz_w[0]  = fold_ff;
   assign cpz_w[0] = fold_pz_ff;
   assign cv_w[0]  = fold_v_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      logic signed [ANG_W-1:0] dx;
      logic signed [ANG_W-1:0] dy;
      logic                    up;

      assign dx = cy_w[i] >>> i;
      assign dy = cx_w[i] >>> i;
      assign up = !cz_w[i][ANG_W-1];

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i] <= 1'b0;
         end else if (adv) begin
            cv_ff[i] <= cv_w[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cx_ff[i]  <= up ? cx_w[i] - dx : cx_w[i] + dx;
            cy_ff[i]  <= up ? cy_w[i] + dy : cy_w[i] - dy;
            cz_ff[i]  <= up ? cz_w[i] - ATAN_Q30[i] : cz_w[i] + ATAN_Q30[i];
            cpz_ff[i] <= cpz_w[i];
         end
      end

      assign cx_w[i+1]  = cx_ff[i];
      assign cy_w[i+1]  = cy_ff[i];
      assign cz_w[i+1]  = cz_ff[i];
      assign cpz_w[i+1] = cpz_ff[i];
      assign cv_w[i+1]  = cv_ff[i];
   end

   // gain stages
   logic signed [65:0] p1_ff;
   logic               p1_v_ff, p1_pz_ff;
   logic signed [35:0] m1;
   logic signed [67:0] p2_ff;
   logic               p2_v_ff, p2_pz_ff;
   logic signed [52:0] sum;
   logic               out_v_ff;
   psin_result_type    out_ff, out_in;

   assign m1  = p1_ff[65:30];
   assign sum = 53'($signed(p2_ff[67:16])) + 53'(cfg.offset);

   always_comb begin
      out_in.period_zero = p2_pz_ff;
      out_in.saturated   = 1'b0;
      out_in.value       = sum[DATA_W-1:0];
      if (p2_pz_ff) begin
         out_in.value = '0;
      end else if (sum > SUM_MAX) begin
         out_in.value     = 32'sh7fffffff;
         out_in.saturated = 1'b1;
      end else if (sum < SUM_MIN) begin
         out_in.value     = 32'sh80000000;
         out_in.saturated = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff  <= 1'b0;
         p2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         p1_v_ff  <= cv_w[CORDIC_STEPS];
         p2_v_ff  <= p1_v_ff;
         out_v_ff <= p2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff    <= 66'(cy_w[CORDIC_STEPS]) * 66'(cfg.amp);
         p1_pz_ff <= cpz_w[CORDIC_STEPS];
         p2_ff    <= 68'(m1) * 68'(cfg.scale);
         p2_pz_ff <= p1_pz_ff;
         out_ff   <= out_in;
      end
   end

   assign res_valid = out_v_ff;
   assign result    = out_ff;

endmodule

[hdl/parametric_sine_oscillator.sv]
// Throughput: one transaction per cycle; the back pipeline (64-stage divider, 8-stage
// angle reduction, 30-stage CORDIC) advances as one unit while the 2-entry result queue
// has room. Reset clears all queues and valid bits and loads register defaults.
// Depends on psin_pkg, psin_front, psin_back.
module parametric_sine_oscillator #(
   parameter int AXIS = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic signed [31:0]  req_time_bars,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic signed [31:0]  rsp_value,
   output logic                rsp_period_zero,
   output logic                rsp_saturated,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_data
);
   import psin_pkg::*;

   localparam int OPTR_W = $clog2(OUT_DEPTH);
   localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

   psin_cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            REG_SPEED:  cfg_in.speed  = csr_data;
            REG_AMP:    cfg_in.amp    = csr_data;
            REG_SCALE:  cfg_in.scale  = csr_data;
            REG_PERIOD: cfg_in.period = csr_data;
            REG_PHASE:  cfg_in.phase  = csr_data;
            REG_OFFSET: cfg_in.offset = csr_data;
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed  <= ONE_Q16;
         cfg_ff.amp    <= ONE_Q16;
         cfg_ff.scale  <= ONE_Q16;
         cfg_ff.period <= ONE_Q16;
         cfg_ff.phase  <= (AXIS == 0) ? PHASE_X_RESET : '0;
         cfg_ff.offset <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // result queue
   psin_result_type  oq_ff [OUT_DEPTH];
   logic [OPTR_W-1:0] owr_ff, owr_in, ord_ff, ord_in;
   logic [OCNT_W-1:0] ocnt_ff, ocnt_in;
   logic              advance, opush, opop, res_valid;
   psin_result_type   result;
   psin_flow_type     flow;
   psin_item_type     head;

   assign advance = (ocnt_ff != OCNT_W'(OUT_DEPTH));
   assign opush   = res_valid && advance;
   assign opop    = rsp_pop && !rsp_empty;

   psin_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_time_bars (req_time_bars),
      .cfg           (cfg_ff),
      .advance       (advance),
      .flow          (flow),
      .head          (head)
   );

   psin_back u_back (
      .clock     (clock),
      .reset     (reset),
      .flow      (flow),
      .item      (head),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .result    (result)
   );

   always_comb begin
      owr_in  = owr_ff;
      ord_in  = ord_ff;
      ocnt_in = ocnt_ff;
      if (opush) begin
         owr_in = (owr_ff == OPTR_W'(OUT_DEPTH - 1)) ? '0 : owr_ff + 1'b1;
      end
      if (opop) begin
         ord_in = (ord_ff == OPTR_W'(OUT_DEPTH - 1)) ? '0 : ord_ff + 1'b1;
      end
      if (opush && !opop) begin
         ocnt_in = ocnt_ff + 1'b1;
      end else if (opop && !opush) begin
         ocnt_in = ocnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ff  <= '0;
         ord_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         owr_ff  <= owr_in;
         ord_ff  <= ord_in;
         ocnt_ff <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (opush) begin
         oq_ff[owr_ff] <= result;
      end
   end

   assign rsp_empty       = (ocnt_ff == '0);
   assign rsp_value       = oq_ff[ord_ff].value;
   assign rsp_period_zero = oq_ff[ord_ff].period_zero;
   assign rsp_saturated   = oq_ff[ord_ff].saturated;

`ifndef ASSERT_OFF
   a_ocnt_bound: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff <= OCNT_W'(OUT_DEPTH))
      else $error("result queue count out of range");

   a_back_hold: assert property (@(posedge clock) disable iff (reset)
      res_valid && !advance |=> res_valid && $stable(result))
      else $error("back pipeline moved while stalled");

   a_pz_zero: assert property (@(posedge clock) disable iff (reset)
      res_valid && result.period_zero |-> result.value == '0 && !result.saturated)
      else $error("zero-period result not cleared");

   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      res_valid && result.saturated |->
         result.value == 32'sh7fffffff || result.value == 32'sh80000000)
      else $error("saturated result not at a bound");
`endif

endmodule

[dv/tb.sv]
// Self-checking bench for parametric_sine_oscillator: time samples are pushed through the
// queue ports and each result is compared against an in-bench fixed-point predictor.
// Depends on psin_pkg and the RTL of the oscillator.
module tb;
   import psin_pkg::*;

   localparam int AXIS_SEL   = 0;
   localparam int IDLE_LIMIT = 4000;
   localparam int N_RANDOM   = 550;

   // Scoreboard: holds the oscillator settings and the queue of predicted results.
   class sine_scoreboard;
      logic signed [31:0] regs [6];
      psin_result_type pending [$];
      int errors;

      function new();
         errors = 0;
         regs[REG_SPEED]  = ONE_Q16;
         regs[REG_AMP]    = ONE_Q16;
         regs[REG_SCALE]  = ONE_Q16;
         regs[REG_PERIOD] = ONE_Q16;
         regs[REG_PHASE]  = (AXIS_SEL == 0) ? PHASE_X_RESET : 32'd0;
         regs[REG_OFFSET] = 32'd0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] data);
         if (idx <= 3'd5) regs[idx] = data;
      endfunction

      function longint fshift(longint v, int sh);
         return v >>> sh;
      endfunction

      function longint sine_q30(longint z);
         longint xv, yv, dx, dy;
         longint atn;
         xv = 652032874;
         yv = 0;
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = fshift(yv, i);
            dy = fshift(xv, i);
            atn = longint'(ATAN_Q30[i]);
            if (z >= 0) begin
               xv -= dx; yv += dy; z -= atn;
            end else begin
               xv += dx; yv -= dy; z += atn;
            end
         end
         return yv;
      endfunction

      function psin_result_type predict(logic signed [31:0] t);
         psin_result_type res;
         longint prod, ang, r, z, a, s, m1, sum;
         longint per;
         longint half, pi30;
         half = longint'(411775) <<< 12;
         pi30 = longint'(411775) <<< 13;
         res = '0;
         per = longint'(regs[REG_PERIOD]);
         if (per == 0) begin
            res.period_zero = 1'b1;
            return res;
         end
         prod = longint'(t) * longint'(regs[REG_SPEED]);
         ang = prod / per + longint'(regs[REG_PHASE]);
         r = ang % 411775;
         if (r < 0) r += 411775;
         z = r <<< 14;
         if (z <= half) a = z;
         else if (z < pi30 + half) a = pi30 - z;
         else a = z - (pi30 <<< 1);
         s = sine_q30(a);
         m1 = fshift(s * longint'(regs[REG_AMP]), 30);
         sum = fshift(m1 * longint'(regs[REG_SCALE]), 16) + longint'(regs[REG_OFFSET]);
         if (sum > 64'sd2147483647) begin
            sum = 64'sd2147483647; res.saturated = 1'b1;
         end else if (sum < -64'sd2147483648) begin
            sum = -64'sd2147483648; res.saturated = 1'b1;
         end
         res.value = sum[31:0];
         return res;
      endfunction

      function void note_sample(logic signed [31:0] t);
         pending.insert(pending.size(), predict(t));
      endfunction

      function void check_result(psin_result_type got);
         psin_result_type exp_r;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result value=%0d", $time, got.value);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (got.value !== exp_r.value) begin
            $display("%0t: value expected %0d actual %0d", $time, exp_r.value, got.value);
            errors++;
         end
         if (got.period_zero !== exp_r.period_zero) begin
            $display("%0t: period_zero expected %0b actual %0b", $time,
                     exp_r.period_zero, got.period_zero);
            errors++;
         end
         if (got.saturated !== exp_r.saturated) begin
            $display("%0t: saturated expected %0b actual %0b", $time,
                     exp_r.saturated, got.saturated);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic signed [31:0] req_time_bars = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic signed [31:0] rsp_value;
   logic rsp_period_zero, rsp_saturated;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   sine_scoreboard sb = new();
   int idle_pct = 22;
   int stall_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   parametric_sine_oscillator #(.AXIS(AXIS_SEL)) u_top (.*);

   // Result side: random pop, check on every accepted transaction.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty)
            sb.check_result(psin_result_type'{value: rsp_value,
                                              period_zero: rsp_period_zero,
                                              saturated: rsp_saturated});
         rsp_pop <= ($urandom_range(99) >= idle_pct);
      end
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else if (!reset)
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // push stays high after the accepting edge; the next idle cycle or drain drops it
   task automatic send_sample(logic signed [31:0] t);
      csr_valid <= 1'b0;
      while ($urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_time_bars <= t;
      do @(posedge clock); while (req_full);
      sb.note_sample(t);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // valid stays high after the write; the following send_sample drops it
   task automatic write_csr(csr_index_type idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(262144) - 131072;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] small_gain();
      return $urandom_range(1, 3) == 1 ? rand_word() : $urandom_range(196608) - 98304;
   endfunction

   initial begin
      logic signed [31:0] edge_times [10];
      edge_times = '{32'sh8000_0000, 32'sh7fff_ffff, 0, 1, -1, 65536, -65536,
                     32'sd411775, 32'sd102943, 32'sd205887};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, field extremes.
      foreach (edge_times[i]) send_sample(edge_times[i]);
      drain();
      // Zero period, then large gains with offset pushing past both bounds.
      write_csr(REG_PERIOD, 32'd0);
      send_sample(32'sd12345);
      send_sample(32'sh8000_0000);
      drain();
      write_csr(REG_PERIOD, 32'h8000_0000);
      write_csr(REG_SPEED, 32'h7fff_ffff);
      write_csr(REG_AMP, 32'h7fff_ffff);
      write_csr(REG_SCALE, 32'h7fff_ffff);
      write_csr(REG_PHASE, 32'h8000_0000);
      write_csr(REG_OFFSET, 32'h7fff_ffff);
      send_sample(32'sh7fff_ffff);
      send_sample(32'sh8000_0000);
      send_sample(32'sd0);
      drain();
      write_csr(REG_OFFSET, 32'h8000_0000);
      write_csr(REG_PERIOD, 32'h7fff_ffff);
      write_csr(REG_PHASE, 32'h7fff_ffff);
      send_sample(32'sd0);
      send_sample(32'sd99999);
      send_sample(-32'sd99999);
      drain();
      // Out-of-range index must be ignored.
      csr_valid <= 1'b1;
      csr_index <= 3'd7;
      csr_data  <= 32'd0;
      do @(posedge clock); while (!csr_ready);
      send_sample(32'sd4242);
      drain();

      // Random phases: new settings, then a burst of samples.
      for (int ph = 0; ph < 11; ph++) begin
         write_csr(REG_SPEED, small_gain());
         write_csr(REG_AMP, small_gain());
         write_csr(REG_SCALE, small_gain());
         write_csr(REG_PERIOD, ($urandom_range(9) == 0) ? 32'd0 : small_gain());
         write_csr(REG_PHASE, rand_word());
         write_csr(REG_OFFSET, rand_word());
         idle_pct = (ph == 5) ? 0 : 22;
         for (int k = 0; k < N_RANDOM / 11; k++) send_sample(rand_word());
         drain();
      end

      drain();
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
